@@ rtl/core/thumb1_data_processing_execute_macros.svh @@
// Assertion helpers used by the top level of the execute unit RTL.
`ifndef THUMB1_DATA_PROCESSING_EXECUTE_MACROS_SVH
`define THUMB1_DATA_PROCESSING_EXECUTE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define T1DPE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define T1DPE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/t1dpe_pkg.sv @@
// ----------------------------------------------------------------------------
// t1dpe_pkg
// Types, opcode constants and datapath helpers of the Thumb-1 execute unit.
// ----------------------------------------------------------------------------
package t1dpe_pkg;

   // Register file geometry
   localparam int NUM_REGS    = 15;
   localparam int REG_AW      = $clog2(NUM_REGS);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] PC_INDEX = 4'd15;
   localparam logic [3:0] SP_INDEX = 4'd13;

   // Top-byte boundaries of the instruction groups
   localparam logic [7:0] HI_SHIFT_END  = 8'h18;
   localparam logic [7:0] HI_ADDSUB_END = 8'h20;
   localparam logic [7:0] HI_IMM8_END   = 8'h40;
   localparam logic [7:0] HI_ALU_END    = 8'h44;
   localparam logic [7:0] HI_HIREG_END  = 8'h47;
   localparam logic [3:0] HI_ADR_NIB    = 4'ha;
   localparam logic [7:0] HI_SPADJ      = 8'hb0;
   localparam logic [7:0] HI_CPS        = 8'hb6;
   localparam logic [7:0] HI_REV        = 8'hba;
   localparam logic [7:0] CPS_IE        = 8'h62;
   localparam logic [7:0] CPS_ID        = 8'h72;

   // Instruction class picked by the front end
   typedef enum logic [3:0] {
      CLS_SHIFT, CLS_ADDSUB, CLS_IMM8, CLS_ALU, CLS_HIREG,
      CLS_ADR, CLS_SPADJ, CLS_CPS, CLS_REV, CLS_UNSUP
   } cls_type;

   typedef enum logic [1:0] {SH_LSL, SH_LSR, SH_ASR, SH_ROR} shk_type;
   typedef enum logic [1:0] {IMM_MOV, IMM_CMP, IMM_ADD, IMM_SUB} imm_type;
   typedef enum logic [1:0] {HR_ADD, HR_CMP, HR_MOV, HR_BX} hr_type;

   typedef enum logic [3:0] {
      ALU_AND, ALU_EOR, ALU_LSL, ALU_LSR, ALU_ASR, ALU_ADC, ALU_SBC, ALU_ROR,
      ALU_TST, ALU_NEG, ALU_CMP, ALU_CMN, ALU_ORR, ALU_MUL, ALU_BIC, ALU_MVN
   } alu_type;

   // Decoded item handed from front to back
   typedef struct packed {
      cls_type     cls;
      logic [15:0] instr;
      logic [31:0] pc4;
      logic [3:0]  ra;
      logic [3:0]  rb;
   } dec_type;

   // Back-end status seen by the top level
   typedef struct packed {
      logic fire;
      logic irq_mask;
   } ex_stat_type;

   // N and Z of a result
   function automatic logic [1:0] nz(logic [31:0] r);
      return {r[31], (r == 32'd0)};
   endfunction

   // x + y + cin, returns {N, Z, C, V, result}
   function automatic logic [35:0] add_nzcv(logic [31:0] x, logic [31:0] y, logic cin);
      logic [32:0] sum;
      logic        v;
      sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
      v   = ~(x[31] ^ y[31]) & (x[31] ^ sum[31]);
      return {sum[31], (sum[31:0] == 32'd0), sum[32], v, sum[31:0]};
   endfunction

   // Barrel shifter, returns {C updated, C, result}
   function automatic logic [33:0] shift_op(shk_type kind, logic [31:0] v, logic [7:0] sh);
      logic [32:0] t;
      logic [63:0] rr;
      logic        c;
      logic [31:0] r;
      t  = '0;
      rr = '0;
      c  = 1'b0;
      r  = v;
      unique case (kind)
         SH_LSL: begin
            if (sh <= 8'd32) begin
               t = {1'b0, v} << sh[5:0];
               c = t[32];
               r = t[31:0];
            end else begin
               c = 1'b0;
               r = '0;
            end
         end
         SH_LSR: begin
            if (sh <= 8'd32) begin
               t = {v, 1'b0} >> sh[5:0];
               c = t[0];
               r = t[32:1];
            end else begin
               c = 1'b0;
               r = '0;
            end
         end
         SH_ASR: begin
            if (sh < 8'd32) begin
               t = 33'($signed({v, 1'b0}) >>> sh[4:0]);
               c = t[0];
               r = t[32:1];
            end else begin
               c = v[31];
               r = {32{v[31]}};
            end
         end
         SH_ROR: begin
            rr = {v, v} >> sh[4:0];
            r  = rr[31:0];
            c  = r[31];
         end
      endcase
      return {(sh != 8'd0), c, r};
   endfunction

endpackage

@@ rtl/core/t1dpe_if.sv @@
// ----------------------------------------------------------------------------
// t1dpe channel interfaces
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
interface t1dpe_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] instr;
   logic [31:0] instr_addr;

   modport source (output valid, instr, instr_addr, input ready);
   modport sink   (input valid, instr, instr_addr, output ready);
endinterface

interface t1dpe_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        reg_write;
   logic [3:0]  reg_index;
   logic [31:0] reg_value;
   logic [3:0]  flags_nzcv;
   logic        branch_taken;
   logic [31:0] branch_target;

   modport source (output valid, status, reg_write, reg_index, reg_value, flags_nzcv,
                   branch_taken, branch_target, input ready);
   modport sink   (input valid, status, reg_write, reg_index, reg_value, flags_nzcv,
                   branch_taken, branch_target, output ready);
endinterface

@@ rtl/core/t1dpe_ram.sv @@
// ----------------------------------------------------------------------------
// t1dpe_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module t1dpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/t1dpe_decode.sv @@
// ----------------------------------------------------------------------------
// t1dpe_decode
// Front end: takes instruction items, classifies them, picks operand registers.
// ----------------------------------------------------------------------------
module t1dpe_decode (
   t1dpe_req_if.sink            req_chan,
   output logic                 push_valid,
   input  logic                 push_ready,
   output t1dpe_pkg::dec_type   push_item
);

   logic [15:0] op;
   logic [7:0]  hi;
   logic [7:0]  lo;

   assign op = req_chan.instr;
   assign hi = op[15:8];
   assign lo = op[7:0];

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

   // class and operand register selection
   always_comb begin
      push_item.instr = op;
      push_item.pc4   = req_chan.instr_addr + 32'd4;
      push_item.ra    = {1'b0, op[5:3]};
      push_item.rb    = {1'b0, op[5:3]};
      push_item.cls   = t1dpe_pkg::CLS_UNSUP;
      priority if (hi < t1dpe_pkg::HI_SHIFT_END) begin
         push_item.cls = t1dpe_pkg::CLS_SHIFT;
      end else if (hi < t1dpe_pkg::HI_ADDSUB_END) begin
         push_item.cls = t1dpe_pkg::CLS_ADDSUB;
         push_item.rb  = {1'b0, op[8:6]};
      end else if (hi < t1dpe_pkg::HI_IMM8_END) begin
         push_item.cls = t1dpe_pkg::CLS_IMM8;
         push_item.ra  = {1'b0, op[10:8]};
      end else if (hi < t1dpe_pkg::HI_ALU_END) begin
         push_item.cls = t1dpe_pkg::CLS_ALU;
         push_item.ra  = {1'b0, op[2:0]};
      end else if (hi < t1dpe_pkg::HI_HIREG_END) begin
         push_item.cls = t1dpe_pkg::CLS_HIREG;
         push_item.ra  = {op[7], op[2:0]};
         push_item.rb  = op[6:3];
      end else if (hi[7:4] == t1dpe_pkg::HI_ADR_NIB) begin
         push_item.cls = t1dpe_pkg::CLS_ADR;
         push_item.ra  = t1dpe_pkg::SP_INDEX;
      end else if (hi == t1dpe_pkg::HI_SPADJ) begin
         push_item.cls = t1dpe_pkg::CLS_SPADJ;
         push_item.ra  = t1dpe_pkg::SP_INDEX;
      end else if (hi == t1dpe_pkg::HI_CPS &&
                   (lo == t1dpe_pkg::CPS_IE || lo == t1dpe_pkg::CPS_ID)) begin
         push_item.cls = t1dpe_pkg::CLS_CPS;
      end else if (hi == t1dpe_pkg::HI_REV && !op[7]) begin
         push_item.cls = t1dpe_pkg::CLS_REV;
      end else begin
         push_item.cls = t1dpe_pkg::CLS_UNSUP;
      end
   end

endmodule

@@ rtl/core/t1dpe_queue.sv @@
// ----------------------------------------------------------------------------
// t1dpe_queue
// Small FIFO of decoded items between front end and back end.
// ----------------------------------------------------------------------------
module t1dpe_queue #(
   parameter int DEPTH = t1dpe_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  t1dpe_pkg::dec_type  push_item,
   output logic                pop_valid,
   input  logic                pop,
   output t1dpe_pkg::dec_type  pop_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   t1dpe_pkg::dec_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

@@ rtl/core/t1dpe_exec.sv @@
// ----------------------------------------------------------------------------
// t1dpe_exec
// Back end: operand read from the register RAMs, execute, result register.
// ----------------------------------------------------------------------------
module t1dpe_exec (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  t1dpe_pkg::dec_type      q_item,
   t1dpe_rsp_if.source             rsp_chan,
   output t1dpe_pkg::ex_stat_type  stat
);

   localparam int NR = t1dpe_pkg::NUM_REGS;
   localparam int AW = t1dpe_pkg::REG_AW;

   // execute stage
   logic               x_valid_ff, x_valid_in;
   t1dpe_pkg::dec_type x_item_ff;
   logic               vld_a_ff, vld_b_ff;
   logic               byp_valid_ff, byp_valid_in;
   logic [3:0]         byp_idx_ff;
   logic [31:0]        byp_val_ff;
   logic [NR-1:0]      reg_vld_ff, reg_vld_in;
   logic [3:0]         flags_ff;
   logic               irq_ff;
   logic               advance;
   logic               x_fire;
   logic [AW-1:0]      ra_addr, rb_addr;
   logic [31:0]        ram_a, ram_b;
   logic [31:0]        a_val, b_val;
   logic [31:0]        mul_lo;

   // execute results
   logic        ex_status;
   logic        ex_wr;
   logic [3:0]  ex_widx;
   logic [31:0] ex_wval;
   logic [3:0]  ex_flags;
   logic        ex_br;
   logic [31:0] ex_tgt;
   logic        ex_irq;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic        out_status_ff;
   logic        out_wr_ff;
   logic [3:0]  out_widx_ff;
   logic [31:0] out_wval_ff;
   logic [3:0]  out_flags_ff;
   logic        out_br_ff;
   logic [31:0] out_tgt_ff;

   // handshake between stages
   assign x_fire  = x_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign advance = q_valid && (!x_valid_ff || x_fire);
   assign q_pop   = advance;

   assign ra_addr = (q_item.ra == t1dpe_pkg::PC_INDEX) ? '0 : q_item.ra[AW-1:0];
   assign rb_addr = (q_item.rb == t1dpe_pkg::PC_INDEX) ? '0 : q_item.rb[AW-1:0];

   // register file: two copies, one read port each
   t1dpe_ram #(.WIDTH(32), .DEPTH(NR)) u_ram_a (
      .clock   (clock),
      .wr_en   (x_fire && ex_wr),
      .wr_addr (ex_widx[AW-1:0]),
      .wr_data (ex_wval),
      .rd_en   (advance),
      .rd_addr (ra_addr),
      .rd_data (ram_a)
   );

   t1dpe_ram #(.WIDTH(32), .DEPTH(NR)) u_ram_b (
      .clock   (clock),
      .wr_en   (x_fire && ex_wr),
      .wr_addr (ex_widx[AW-1:0]),
      .wr_data (ex_wval),
      .rd_en   (advance),
      .rd_addr (rb_addr),
      .rd_data (ram_b)
   );

   // operands: PC, bypass of the write made during the read, RAM, or reset zero
   always_comb begin
      if (x_item_ff.ra == t1dpe_pkg::PC_INDEX) a_val = x_item_ff.pc4;
      else if (byp_valid_ff && byp_idx_ff == x_item_ff.ra) a_val = byp_val_ff;
      else a_val = vld_a_ff ? ram_a : 32'd0;
      if (x_item_ff.rb == t1dpe_pkg::PC_INDEX) b_val = x_item_ff.pc4;
      else if (byp_valid_ff && byp_idx_ff == x_item_ff.rb) b_val = byp_val_ff;
      else b_val = vld_b_ff ? ram_b : 32'd0;
   end

   assign mul_lo = a_val * b_val;

   // instruction semantics
   always_comb begin
      logic [15:0] op;
      logic [31:0] low8;
      logic [31:0] res;
      logic        wr;
      logic [3:0]  dst;
      logic [35:0] ad;
      logic [33:0] sr;
      logic [7:0]  amt;
      logic [31:0] m;
      logic [3:0]  hd;
      logic [31:0] base;
      logic [31:0] off;
      op        = x_item_ff.instr;
      low8      = {24'd0, op[7:0]};
      res       = '0;
      wr        = 1'b0;
      dst       = {1'b0, op[2:0]};
      ad        = '0;
      sr        = '0;
      amt       = '0;
      m         = '0;
      hd        = {op[7], op[2:0]};
      base      = '0;
      off       = '0;
      ex_status = 1'b0;
      ex_flags  = flags_ff;
      ex_br     = 1'b0;
      ex_tgt    = '0;
      ex_irq    = irq_ff;
      unique case (x_item_ff.cls)
         t1dpe_pkg::CLS_SHIFT: begin
            amt = {3'd0, op[10:6]};
            if (op[12:11] != 2'd0 && op[10:6] == 5'd0) amt = 8'd32;
            sr  = t1dpe_pkg::shift_op(t1dpe_pkg::shk_type'(op[12:11]), a_val, amt);
            res = sr[31:0];
            ex_flags = {t1dpe_pkg::nz(res), sr[33] ? sr[32] : flags_ff[1], flags_ff[0]};
            wr  = 1'b1;
         end
         t1dpe_pkg::CLS_ADDSUB: begin
            m  = op[10] ? {29'd0, op[8:6]} : b_val;
            ad = op[9] ? t1dpe_pkg::add_nzcv(a_val, ~m, 1'b1)
                       : t1dpe_pkg::add_nzcv(a_val, m, 1'b0);
            res = ad[31:0];
            ex_flags = ad[35:32];
            wr  = 1'b1;
         end
         t1dpe_pkg::CLS_IMM8: begin
            dst = {1'b0, op[10:8]};
            unique case (t1dpe_pkg::imm_type'(op[12:11]))
               t1dpe_pkg::IMM_MOV: begin
                  res = low8;
                  ex_flags = {t1dpe_pkg::nz(res), flags_ff[1:0]};
                  wr  = 1'b1;
               end
               t1dpe_pkg::IMM_CMP: begin
                  ad = t1dpe_pkg::add_nzcv(a_val, ~low8, 1'b1);
                  ex_flags = ad[35:32];
               end
               t1dpe_pkg::IMM_ADD: begin
                  ad  = t1dpe_pkg::add_nzcv(a_val, low8, 1'b0);
                  res = ad[31:0];
                  ex_flags = ad[35:32];
                  wr  = 1'b1;
               end
               t1dpe_pkg::IMM_SUB: begin
                  ad  = t1dpe_pkg::add_nzcv(a_val, ~low8, 1'b1);
                  res = ad[31:0];
                  ex_flags = ad[35:32];
                  wr  = 1'b1;
               end
            endcase
         end
         t1dpe_pkg::CLS_ALU: begin
            wr = 1'b1;
            unique case (t1dpe_pkg::alu_type'(op[9:6]))
               t1dpe_pkg::ALU_AND: res = a_val & b_val;
               t1dpe_pkg::ALU_EOR: res = a_val ^ b_val;
               t1dpe_pkg::ALU_LSL: sr = t1dpe_pkg::shift_op(t1dpe_pkg::SH_LSL, a_val, b_val[7:0]);
               t1dpe_pkg::ALU_LSR: sr = t1dpe_pkg::shift_op(t1dpe_pkg::SH_LSR, a_val, b_val[7:0]);
               t1dpe_pkg::ALU_ASR: sr = t1dpe_pkg::shift_op(t1dpe_pkg::SH_ASR, a_val, b_val[7:0]);
               t1dpe_pkg::ALU_ADC: ad = t1dpe_pkg::add_nzcv(a_val, b_val, flags_ff[1]);
               t1dpe_pkg::ALU_SBC: ad = t1dpe_pkg::add_nzcv(a_val, ~b_val, flags_ff[1]);
               t1dpe_pkg::ALU_ROR: sr = t1dpe_pkg::shift_op(t1dpe_pkg::SH_ROR, a_val, b_val[7:0]);
               t1dpe_pkg::ALU_TST: begin
                  res = a_val & b_val;
                  wr  = 1'b0;
               end
               t1dpe_pkg::ALU_NEG: ad = t1dpe_pkg::add_nzcv(~b_val, 32'd0, 1'b1);
               t1dpe_pkg::ALU_CMP: begin
                  ad = t1dpe_pkg::add_nzcv(a_val, ~b_val, 1'b1);
                  wr = 1'b0;
               end
               t1dpe_pkg::ALU_CMN: begin
                  ad = t1dpe_pkg::add_nzcv(a_val, b_val, 1'b0);
                  wr = 1'b0;
               end
               t1dpe_pkg::ALU_ORR: res = a_val | b_val;
               t1dpe_pkg::ALU_MUL: res = mul_lo;
               t1dpe_pkg::ALU_BIC: res = a_val & ~b_val;
               t1dpe_pkg::ALU_MVN: res = ~b_val;
            endcase
            // flag update by operation kind
            unique case (t1dpe_pkg::alu_type'(op[9:6]))
               t1dpe_pkg::ALU_LSL, t1dpe_pkg::ALU_LSR, t1dpe_pkg::ALU_ASR,
               t1dpe_pkg::ALU_ROR: begin
                  res = sr[31:0];
                  ex_flags = {t1dpe_pkg::nz(res), sr[33] ? sr[32] : flags_ff[1], flags_ff[0]};
               end
               t1dpe_pkg::ALU_ADC, t1dpe_pkg::ALU_SBC, t1dpe_pkg::ALU_NEG,
               t1dpe_pkg::ALU_CMP, t1dpe_pkg::ALU_CMN: begin
                  res = ad[31:0];
                  ex_flags = ad[35:32];
               end
               default: ex_flags = {t1dpe_pkg::nz(res), flags_ff[1:0]};
            endcase
         end
         t1dpe_pkg::CLS_HIREG: begin
            if (t1dpe_pkg::hr_type'(op[9:8]) == t1dpe_pkg::HR_CMP) begin
               ad = t1dpe_pkg::add_nzcv(a_val, ~b_val, 1'b1);
               ex_flags = ad[35:32];
            end else if (!(t1dpe_pkg::hr_type'(op[9:8]) == t1dpe_pkg::HR_MOV &&
                           hd == 4'd8 && op[6:3] == 4'd8)) begin
               res = (t1dpe_pkg::hr_type'(op[9:8]) == t1dpe_pkg::HR_ADD) ? a_val + b_val : b_val;
               if (hd == t1dpe_pkg::PC_INDEX) begin
                  ex_br  = 1'b1;
                  ex_tgt = {res[31:1], 1'b0};
               end else begin
                  dst = hd;
                  wr  = 1'b1;
               end
            end
         end
         t1dpe_pkg::CLS_ADR: begin
            base = op[11] ? a_val : {x_item_ff.pc4[31:2], 2'b00};
            res  = base + {22'd0, op[7:0], 2'b00};
            dst  = {1'b0, op[10:8]};
            wr   = 1'b1;
         end
         t1dpe_pkg::CLS_SPADJ: begin
            off = {23'd0, op[6:0], 2'b00};
            res = op[7] ? a_val - off : a_val + off;
            dst = t1dpe_pkg::SP_INDEX;
            wr  = 1'b1;
         end
         t1dpe_pkg::CLS_CPS: begin
            ex_irq = (op[7:0] == t1dpe_pkg::CPS_ID);
         end
         t1dpe_pkg::CLS_REV: begin
            res = op[6] ? {a_val[23:16], a_val[31:24], a_val[7:0], a_val[15:8]}
                        : {a_val[7:0], a_val[15:8], a_val[23:16], a_val[31:24]};
            wr  = 1'b1;
         end
         default: ex_status = 1'b1;
      endcase
      ex_wr   = wr;
      ex_widx = wr ? dst : 4'd0;
      ex_wval = wr ? res : 32'd0;
   end

   // stage control
   always_comb begin
      x_valid_in   = advance || (x_valid_ff && !x_fire);
      byp_valid_in = byp_valid_ff;
      if (advance) byp_valid_in = x_fire && ex_wr;
      reg_vld_in   = reg_vld_ff;
      if (x_fire && ex_wr) reg_vld_in = reg_vld_ff | (NR'(1) << ex_widx[AW-1:0]);
      out_valid_in = x_fire || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         byp_valid_ff <= 1'b0;
         reg_vld_ff   <= '0;
         flags_ff     <= '0;
         irq_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         x_valid_ff   <= x_valid_in;
         byp_valid_ff <= byp_valid_in;
         reg_vld_ff   <= reg_vld_in;
         out_valid_ff <= out_valid_in;
         if (x_fire) begin
            flags_ff <= ex_flags;
            irq_ff   <= ex_irq;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         x_item_ff  <= q_item;
         vld_a_ff   <= reg_vld_ff[ra_addr];
         vld_b_ff   <= reg_vld_ff[rb_addr];
         byp_idx_ff <= ex_widx;
         byp_val_ff <= ex_wval;
      end
      if (x_fire) begin
         out_status_ff <= ex_status;
         out_wr_ff     <= ex_wr;
         out_widx_ff   <= ex_widx;
         out_wval_ff   <= ex_wval;
         out_flags_ff  <= ex_flags;
         out_br_ff     <= ex_br;
         out_tgt_ff    <= ex_tgt;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.reg_write     = out_wr_ff;
   assign rsp_chan.reg_index     = out_widx_ff;
   assign rsp_chan.reg_value     = out_wval_ff;
   assign rsp_chan.flags_nzcv    = out_flags_ff;
   assign rsp_chan.branch_taken  = out_br_ff;
   assign rsp_chan.branch_target = out_tgt_ff;

   assign stat.fire     = x_fire;
   assign stat.irq_mask = irq_ff;

endmodule

@@ rtl/core/thumb1_data_processing_execute.sv @@
// Path: an accepted item goes into a queue slot, then with its register operands
// into the execute stage registers, and from there into the result register.
// Throughput: one item per cycle unless rsp_chan stalls; execute stage and register
// RAM read port each handle one item per clock, with a bypass for back-to-back writes.
// Reset: synchronous, active high; registers read as zero until written (per-entry
// valid bits), flags and interrupt mask clear, no clearing pass.
// ----------------------------------------------------------------------------
// thumb1_data_processing_execute
// Thumb-1 data-processing execute unit: decode front, item queue, execute back.
// ----------------------------------------------------------------------------
`include "thumb1_data_processing_execute_macros.svh"

module thumb1_data_processing_execute #(
   parameter int QUEUE_DEPTH = t1dpe_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   t1dpe_req_if.sink   req_chan,
   t1dpe_rsp_if.source rsp_chan
);

   logic                   push_valid;
   logic                   push_ready;
   t1dpe_pkg::dec_type     push_item;
   logic                   pop_valid;
   logic                   pop;
   t1dpe_pkg::dec_type     pop_item;
   t1dpe_pkg::ex_stat_type exec_st;

   // front end
   t1dpe_decode u_decode (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decoupling queue
   t1dpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   // back end
   t1dpe_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (pop_valid),
      .q_pop    (pop),
      .q_item   (pop_item),
      .rsp_chan (rsp_chan),
      .stat     (exec_st)
   );

   // checks
   `T1DPE_ASSERT_NOW(a_unsup_quiet, rsp_chan.valid && rsp_chan.status, !rsp_chan.reg_write && !rsp_chan.branch_taken, "unsupported item changed state")
   `T1DPE_ASSERT_NOW(a_branch_form, rsp_chan.valid && rsp_chan.branch_taken, !rsp_chan.branch_target[0] && !rsp_chan.reg_write, "bad branch result")
   `T1DPE_ASSERT_NOW(a_no_pc_write, rsp_chan.valid && rsp_chan.reg_write, rsp_chan.reg_index != t1dpe_pkg::PC_INDEX, "write to PC index")
   `T1DPE_ASSERT_NEXT(a_irq_hold, !exec_st.fire, $stable(exec_st.irq_mask), "mask changed without an item")

endmodule

@@ dv/t1dpe_tb_if.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench channel notes
// The channel interfaces come from the RTL; this file holds the result item
// type the testbench checker queues, and the instruction item type to drive.
// ----------------------------------------------------------------------------
package t1dpe_tb_pkg;

   // One expected result item
   typedef struct {
      logic        status;
      logic        reg_write;
      logic [3:0]  reg_index;
      logic [31:0] reg_value;
      logic [3:0]  flags_nzcv;
      logic        branch_taken;
      logic [31:0] branch_target;
   } exec_result_type;

   // One instruction item to drive
   typedef struct {
      logic [15:0] instr;
      logic [31:0] instr_addr;
   } instr_item_type;

endpackage

@@ dv/tb_thumb1_data_processing_execute.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Thumb-1 execute unit testbench
// Drives directed and random instruction items with random gaps and stalls,
// predicts each result with a model of the register file, flags and PRIMASK,
// and checks every result item field by field in order.
// ----------------------------------------------------------------------------
module tb_thumb1_data_processing_execute;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_RANDOM     = 500;

   logic clock;
   logic reset;

   t1dpe_req_if req_chan ();
   t1dpe_rsp_if rsp_chan ();

   thumb1_data_processing_execute u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   // Clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state
   logic [31:0]  arch_regs [15];
   logic [3:0]   arch_flags;
   logic         arch_primask;

   t1dpe_tb_pkg::instr_item_type  pending_instrs [$];
   t1dpe_tb_pkg::exec_result_type expected_results [$];
   int           error_count;
   int           stall_cycles;
   bit           stim_done;
   bit           req_fired;
   bit           rsp_fired;

   // N and Z into the predicted flags
   function automatic void put_nz(logic [31:0] r);
      arch_flags[3] = r[31];
      arch_flags[2] = (r == 32'd0);
   endfunction

   // Add with carry, updating all four flags
   function automatic logic [31:0] add_with_flags(logic [31:0] x, logic [31:0] y, logic cin);
      logic [32:0] sum;
      sum = {1'b0, x} + {1'b0, y} + 33'(cin);
      put_nz(sum[31:0]);
      arch_flags[1] = sum[32];
      arch_flags[0] = ~(x[31] ^ y[31]) & (x[31] ^ sum[31]);
      return sum[31:0];
   endfunction

   // Barrel shift; carry changes only for a nonzero amount
   function automatic logic [31:0] barrel(t1dpe_pkg::shk_type kind, logic [31:0] v,
                                          int unsigned sh);
      logic [31:0] r;
      int unsigned s;
      r = v;
      if (sh == 0) return v;
      case (kind)
         t1dpe_pkg::SH_LSL: begin
            if (sh < 32) begin
               arch_flags[1] = v[32 - sh];
               r = v << sh;
            end else begin
               arch_flags[1] = (sh == 32) ? v[0] : 1'b0;
               r = '0;
            end
         end
         t1dpe_pkg::SH_LSR: begin
            if (sh < 32) begin
               arch_flags[1] = v[sh - 1];
               r = v >> sh;
            end else begin
               arch_flags[1] = (sh == 32) ? v[31] : 1'b0;
               r = '0;
            end
         end
         t1dpe_pkg::SH_ASR: begin
            if (sh < 32) begin
               arch_flags[1] = v[sh - 1];
               r = 32'($signed(v) >>> sh);
            end else begin
               arch_flags[1] = v[31];
               r = {32{v[31]}};
            end
         end
         default: begin
            s = sh % 32;
            if (s != 0) r = (v >> s) | (v << (32 - s));
            arch_flags[1] = r[31];
         end
      endcase
      return r;
   endfunction

   // Execute one instruction on the predicted state
   function automatic t1dpe_tb_pkg::exec_result_type execute_instr(logic [15:0] op,
                                                                  logic [31:0] addr);
      t1dpe_tb_pkg::exec_result_type o;
      logic [31:0]  pc4, res, vd, vm, d, m, base;
      logic [7:0]   hb, lb;
      logic [3:0]   rd, rm, hd, hm;
      logic [31:0]  f;
      bit           wr;
      pc4 = addr + 32'd4;
      hb  = op[15:8];
      lb  = op[7:0];
      rd  = {1'b0, op[2:0]};
      rm  = {1'b0, op[5:3]};
      res = '0;
      wr  = 0;
      o   = '{default: '0};
      if (hb < t1dpe_pkg::HI_SHIFT_END) begin
         f = {27'd0, op[10:6]};
         if (op[12:11] != 2'd0 && f == 0) f = 32;
         res = barrel(t1dpe_pkg::shk_type'(op[12:11]), arch_regs[rm], f);
         put_nz(res);
         wr = 1;
      end else if (hb < t1dpe_pkg::HI_ADDSUB_END) begin
         m   = op[10] ? {29'd0, op[8:6]} : arch_regs[op[8:6]];
         res = op[9] ? add_with_flags(arch_regs[rm], ~m, 1'b1)
                     : add_with_flags(arch_regs[rm], m, 1'b0);
         wr  = 1;
      end else if (hb < t1dpe_pkg::HI_IMM8_END) begin
         rd = {1'b0, op[10:8]};
         case (t1dpe_pkg::imm_type'(op[12:11]))
            t1dpe_pkg::IMM_MOV: begin res = {24'd0, lb}; put_nz(res); wr = 1; end
            t1dpe_pkg::IMM_CMP: void'(add_with_flags(arch_regs[rd], ~{24'd0, lb}, 1'b1));
            t1dpe_pkg::IMM_ADD: begin
               res = add_with_flags(arch_regs[rd], {24'd0, lb}, 1'b0);
               wr  = 1;
            end
            default: begin res = add_with_flags(arch_regs[rd], ~{24'd0, lb}, 1'b1); wr = 1; end
         endcase
      end else if (hb < t1dpe_pkg::HI_ALU_END) begin
         d  = arch_regs[rd];
         m  = arch_regs[rm];
         wr = 1;
         case (t1dpe_pkg::alu_type'(op[9:6]))
            t1dpe_pkg::ALU_AND: begin res = d & m; put_nz(res); end
            t1dpe_pkg::ALU_EOR: begin res = d ^ m; put_nz(res); end
            t1dpe_pkg::ALU_LSL: begin res = barrel(t1dpe_pkg::SH_LSL, d, m[7:0]); put_nz(res); end
            t1dpe_pkg::ALU_LSR: begin res = barrel(t1dpe_pkg::SH_LSR, d, m[7:0]); put_nz(res); end
            t1dpe_pkg::ALU_ASR: begin res = barrel(t1dpe_pkg::SH_ASR, d, m[7:0]); put_nz(res); end
            t1dpe_pkg::ALU_ADC: res = add_with_flags(d, m, arch_flags[1]);
            t1dpe_pkg::ALU_SBC: res = add_with_flags(d, ~m, arch_flags[1]);
            t1dpe_pkg::ALU_ROR: begin res = barrel(t1dpe_pkg::SH_ROR, d, m[7:0]); put_nz(res); end
            t1dpe_pkg::ALU_TST: begin put_nz(d & m); wr = 0; end
            t1dpe_pkg::ALU_NEG: res = add_with_flags(~m, 32'd0, 1'b1);
            t1dpe_pkg::ALU_CMP: begin void'(add_with_flags(d, ~m, 1'b1)); wr = 0; end
            t1dpe_pkg::ALU_CMN: begin void'(add_with_flags(d, m, 1'b0)); wr = 0; end
            t1dpe_pkg::ALU_ORR: begin res = d | m; put_nz(res); end
            t1dpe_pkg::ALU_MUL: begin res = d * m; put_nz(res); end
            t1dpe_pkg::ALU_BIC: begin res = d & ~m; put_nz(res); end
            default: begin res = ~m; put_nz(res); end
         endcase
      end else if (hb < t1dpe_pkg::HI_HIREG_END) begin
         hd = {op[7], op[2:0]};
         hm = op[6:3];
         vd = (hd == t1dpe_pkg::PC_INDEX) ? pc4 : arch_regs[hd];
         vm = (hm == t1dpe_pkg::PC_INDEX) ? pc4 : arch_regs[hm];
         if (t1dpe_pkg::hr_type'(hb[1:0]) == t1dpe_pkg::HR_CMP) begin
            void'(add_with_flags(vd, ~vm, 1'b1));
         end else if (!(t1dpe_pkg::hr_type'(hb[1:0]) == t1dpe_pkg::HR_MOV
                        && hd == 4'd8 && hm == 4'd8)) begin
            res = (t1dpe_pkg::hr_type'(hb[1:0]) == t1dpe_pkg::HR_ADD) ? vd + vm : vm;
            if (hd == t1dpe_pkg::PC_INDEX) begin
               o.branch_taken  = 1'b1;
               o.branch_target = res & ~32'd1;
            end else begin
               rd = hd;
               wr = 1;
            end
         end
      end else if (hb[7:4] == t1dpe_pkg::HI_ADR_NIB) begin
         base = op[11] ? arch_regs[t1dpe_pkg::SP_INDEX] : (pc4 & ~32'd3);
         rd   = {1'b0, op[10:8]};
         res  = base + {22'd0, lb, 2'b00};
         wr   = 1;
      end else if (hb == t1dpe_pkg::HI_SPADJ) begin
         rd  = t1dpe_pkg::SP_INDEX;
         res = op[7] ? arch_regs[t1dpe_pkg::SP_INDEX] - {23'd0, op[6:0], 2'b00}
                     : arch_regs[t1dpe_pkg::SP_INDEX] + {23'd0, op[6:0], 2'b00};
         wr  = 1;
      end else if (hb == t1dpe_pkg::HI_CPS
                   && (lb == t1dpe_pkg::CPS_IE || lb == t1dpe_pkg::CPS_ID)) begin
         arch_primask = (lb == t1dpe_pkg::CPS_ID);
      end else if (hb == t1dpe_pkg::HI_REV && op[7:6] < 2'd2) begin
         m   = arch_regs[rm];
         res = op[6] ? {m[23:16], m[31:24], m[7:0], m[15:8]}
                     : {m[7:0], m[15:8], m[23:16], m[31:24]};
         wr  = 1;
      end else begin
         o.status = 1'b1;
      end
      if (wr && rd < t1dpe_pkg::PC_INDEX) begin
         arch_regs[rd] = res;
         o.reg_write   = 1'b1;
         o.reg_index   = rd;
         o.reg_value   = res;
      end
      o.flags_nzcv = arch_flags;
      return o;
   endfunction

   function automatic void push_instr(logic [15:0] op);
      t1dpe_tb_pkg::instr_item_type it;
      it.instr      = op;
      it.instr_addr = $urandom();
      pending_instrs.push_back(it);
   endfunction

   // Random instruction, mostly from the executed groups
   function automatic logic [15:0] rand_instr();
      logic [15:0] op;
      op = 16'($urandom());
      case ($urandom_range(0, 11))
         0:  op[15:13] = 3'b000;
         1:  op[15:11] = 5'b00011;
         2:  op[15:13] = 3'b001;
         3, 4: op[15:10] = 6'b010000;
         5:  begin op[15:10] = 6'b010001; op[9:8] = 2'($urandom_range(0, 2)); end
         6:  op[15:12] = 4'ha;
         7:  op[15:8] = t1dpe_pkg::HI_SPADJ;
         8:  begin
            op[15:8] = t1dpe_pkg::HI_CPS;
            op[7:0]  = op[0] ? t1dpe_pkg::CPS_ID : t1dpe_pkg::CPS_IE;
         end
         9:  op[15:8] = t1dpe_pkg::HI_REV;
         10: op[15:8] = 8'h20 | {5'd0, op[2:0]};  // MOVS with random byte
         default: ;
      endcase
      return op;
   endfunction

   // Stimulus
   initial begin
      int n;
      reset     = 1'b1;
      stim_done = 0;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      arch_flags   = '0;
      arch_primask = 1'b0;
      // Directed: seed registers, then extremes and special cases
      push_instr(16'h20ff);   // movs r0,#255
      push_instr(16'h4240);   // negs r0,r0 -> 0xffffff01
      push_instr(16'h2120);   // movs r1,#32
      push_instr(16'h0002);   // movs r2,r0
      push_instr(16'h408a);   // lsls r2,r1 (by 32)
      push_instr(16'h0002);
      push_instr(16'h40ca);   // lsrs r2,r1
      push_instr(16'h0002);
      push_instr(16'h410a);   // asrs r2,r1
      push_instr(16'h0002);
      push_instr(16'h41ca);   // rors r2,r1
      push_instr(16'h0fc3);   // lsrs r3,r0,#31
      push_instr(16'h17c4);   // asrs r4,r0,#31
      push_instr(16'h4145);   // adcs
      push_instr(16'h4185);   // sbcs
      push_instr(16'h4345);   // muls
      push_instr(16'h4287);   // cmp r7,r0
      push_instr(16'h4687);   // mov pc,r0
      push_instr(16'h4487);   // add pc,r0
      push_instr(16'h46c0);   // mov r8,r8
      push_instr(16'h45ff);   // cmp pc,pc
      push_instr(16'h4281);   // cmp r1,r0 (low register form)
      push_instr(16'hb672);   // cpsid
      push_instr(16'hb662);   // cpsie
      push_instr(16'hb663);   // bad cps
      push_instr(16'hbac1);   // revsh
      push_instr(16'hba01);   // rev
      push_instr(16'hffff);
      for (n = 0; n < NUM_RANDOM; n++) push_instr(rand_instr());
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: one item at a time, random gap before each
   int gap_left;
   bit gap_drawn;
   initial begin
      req_chan.valid      = 1'b0;
      req_chan.instr      = '0;
      req_chan.instr_addr = '0;
      rsp_chan.ready      = 1'b0;
      gap_drawn           = 0;
      gap_left            = 0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_chan.valid && !req_fired) begin
            // hold
         end else if (pending_instrs.size() == 0) begin
            req_chan.valid <= 1'b0;
            stim_done      <= 1;
         end else begin
            if (!gap_drawn) begin
               gap_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
               gap_drawn = 1;
            end
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else begin
               req_chan.valid      <= 1'b1;
               req_chan.instr      <= pending_instrs[0].instr;
               req_chan.instr_addr <= pending_instrs[0].instr_addr;
               void'(pending_instrs.pop_front());
               gap_drawn = 0;
            end
         end
      end
   end

   // Result side stall
   int stall_left;
   initial stall_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (rsp_fired)
               stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         end
      end
   end

   // Handshakes seen at the last rising edge
   always @(posedge clock) begin
      req_fired <= req_chan.valid && req_chan.ready;
      rsp_fired <= rsp_chan.valid && rsp_chan.ready;
   end

   // Monitor: predict on accepted items, check accepted results
   initial begin
      error_count  = 0;
      stall_cycles = 0;
   end

   always @(posedge clock) begin
      t1dpe_tb_pkg::exec_result_type exp_r;
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(execute_instr(req_chan.instr, req_chan.instr_addr));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result item");
               error_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_chan.status !== exp_r.status) begin
                  $error("status exp %0h got %0h", exp_r.status, rsp_chan.status);
                  error_count++;
               end
               if (rsp_chan.reg_write !== exp_r.reg_write) begin
                  $error("reg_write exp %0h got %0h", exp_r.reg_write, rsp_chan.reg_write);
                  error_count++;
               end
               if (rsp_chan.reg_index !== exp_r.reg_index) begin
                  $error("reg_index exp %0h got %0h", exp_r.reg_index, rsp_chan.reg_index);
                  error_count++;
               end
               if (rsp_chan.reg_value !== exp_r.reg_value) begin
                  $error("reg_value exp %0h got %0h", exp_r.reg_value, rsp_chan.reg_value);
                  error_count++;
               end
               if (rsp_chan.flags_nzcv !== exp_r.flags_nzcv) begin
                  $error("flags_nzcv exp %0h got %0h", exp_r.flags_nzcv, rsp_chan.flags_nzcv);
                  error_count++;
               end
               if (rsp_chan.branch_taken !== exp_r.branch_taken) begin
                  $error("branch_taken exp %0h got %0h", exp_r.branch_taken,
                         rsp_chan.branch_taken);
                  error_count++;
               end
               if (rsp_chan.branch_target !== exp_r.branch_target) begin
                  $error("branch_target exp %0h got %0h", exp_r.branch_target,
                         rsp_chan.branch_target);
                  error_count++;
               end
            end
         end
      end
   end

   // End of run and watchdog
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
         if (stim_done && pending_instrs.size() == 0 && !req_chan.valid
             && expected_results.size() == 0) begin
            repeat (10) @(posedge clock);
            if (error_count == 0 && expected_results.size() == 0)
               $display("tb: success");
            else
               $display("tb: failure");
            $finish;
         end
      end
   end

endmodule
